### hw/rtl/rgbmm_pkg.sv
// Types, step codes and step schedule tables shared by the median-then-mean filter.
// No dependencies.
`timescale 1ns / 1ps

package rgbmm_pkg;

    typedef enum logic [1:0] {
        STEP_FULL  = 2'd0,
        STEP_LEFT  = 2'd1,
        STEP_UP    = 2'd2,
        STEP_RIGHT = 2'd3
    } step_kind_t;

    localparam logic [5:0] ROW_LAST_POS = 6'd32;
    localparam logic [5:0] MID_LAST_POS = 6'd14;

    typedef struct packed {
        logic       we;
        logic       shift;
        step_kind_t kind;
        logic [3:0] slot;
    } win_op_t;

    typedef struct packed {
        logic       med;
        logic [3:0] idx;
        logic       shift;
        logic       emit;
    } grid_op_t;

    function automatic step_kind_t row_kind(input logic [3:0] step);
        step_kind_t k;
        case (step)
            4'd0:    k = STEP_FULL;
            4'd1:    k = STEP_LEFT;
            4'd2:    k = STEP_LEFT;
            4'd3:    k = STEP_UP;
            4'd4:    k = STEP_RIGHT;
            4'd5:    k = STEP_RIGHT;
            4'd6:    k = STEP_UP;
            4'd7:    k = STEP_LEFT;
            4'd8:    k = STEP_LEFT;
            default: k = STEP_FULL;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] row_cell(input logic [3:0] step);
        logic [3:0] c;
        case (step)
            4'd0:    c = 4'd0;
            4'd1:    c = 4'd1;
            4'd2:    c = 4'd2;
            4'd3:    c = 4'd5;
            4'd4:    c = 4'd4;
            4'd5:    c = 4'd3;
            4'd6:    c = 4'd6;
            4'd7:    c = 4'd7;
            4'd8:    c = 4'd8;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

    function automatic step_kind_t mid_kind(input logic [3:0] step);
        step_kind_t k;
        case (step)
            4'd0:    k = STEP_FULL;
            4'd1:    k = STEP_UP;
            4'd2:    k = STEP_UP;
            default: k = STEP_FULL;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] mid_cell(input logic [3:0] step);
        logic [3:0] c;
        case (step)
            4'd0:    c = 4'd2;
            4'd1:    c = 4'd5;
            4'd2:    c = 4'd8;
            default: c = 4'd2;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/rgbmm_lane.sv
// One color channel: 3x3 window, two-stage median-of-nine network, median grid,
// weighted sum and reciprocal divide by ten. Depends on rgbmm_pkg.
`timescale 1ns / 1ps

module rgbmm_lane #(
    parameter int PB = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [PB-1:0]       pix,
    input  rgbmm_pkg::win_op_t  win_op,
    input  rgbmm_pkg::grid_op_t grid_op,
    output logic [PB-1:0]       quot
);

    localparam int SW = PB + 4;
    localparam int SH = SW + 4;
    localparam logic [SW:0] MUL = (SW+1)'((64'd1 << SH) / 10 + 1);

    logic [PB-1:0] window_reg [9];
    logic [PB-1:0] window_next [9];
    logic [PB-1:0] part_reg [9];
    logic [PB-1:0] part_next [9];
    logic [PB-1:0] grid_reg [9];
    logic [PB-1:0] grid_next [9];
    logic [PB-1:0] fin [9];
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_next;
    logic [2*SW:0] prod;

    function automatic void cx(inout logic [PB-1:0] a, inout logic [PB-1:0] b);
        logic [PB-1:0] t;
        t = a;
        if (a > b)
        begin
            a = b;
            b = t;
        end
    endfunction

    always_comb
    begin
        window_next = window_reg;
        if (win_op.shift)
        begin
            case (win_op.kind)
                rgbmm_pkg::STEP_LEFT:
                begin
                    for (int y = 0; y < 3; y++)
                    begin
                        window_next[y*3]   = window_reg[y*3+1];
                        window_next[y*3+1] = window_reg[y*3+2];
                    end
                end
                rgbmm_pkg::STEP_RIGHT:
                begin
                    for (int y = 0; y < 3; y++)
                    begin
                        window_next[y*3+2] = window_reg[y*3+1];
                        window_next[y*3+1] = window_reg[y*3];
                    end
                end
                rgbmm_pkg::STEP_UP:
                begin
                    for (int x = 0; x < 3; x++)
                    begin
                        window_next[x]   = window_reg[3+x];
                        window_next[3+x] = window_reg[6+x];
                    end
                end
                default:
                begin
                    window_next = window_reg;
                end
            endcase
        end
        if (win_op.we)
        begin
            window_next[win_op.slot] = pix;
        end
    end

    // row sorts
    always_comb
    begin
        part_next = window_reg;
        cx(part_next[1], part_next[2]);
        cx(part_next[4], part_next[5]);
        cx(part_next[7], part_next[8]);
        cx(part_next[0], part_next[1]);
        cx(part_next[3], part_next[4]);
        cx(part_next[6], part_next[7]);
        cx(part_next[1], part_next[2]);
        cx(part_next[4], part_next[5]);
        cx(part_next[7], part_next[8]);
    end

    always_comb
    begin
        fin = part_reg;
        cx(fin[0], fin[3]);
        cx(fin[5], fin[8]);
        cx(fin[4], fin[7]);
        cx(fin[3], fin[6]);
        cx(fin[1], fin[4]);
        cx(fin[2], fin[5]);
        cx(fin[4], fin[7]);
        cx(fin[4], fin[2]);
        cx(fin[6], fin[4]);
        cx(fin[4], fin[2]);
    end

    always_comb
    begin
        grid_next = grid_reg;
        if (grid_op.shift)
        begin
            for (int y = 0; y < 3; y++)
            begin
                grid_next[y*3]   = grid_reg[y*3+1];
                grid_next[y*3+1] = grid_reg[y*3+2];
            end
        end
        if (grid_op.med)
        begin
            grid_next[grid_op.idx] = fin[4];
        end
    end

    always_comb
    begin
        sum_next = SW'(grid_reg[4]);
        for (int i = 0; i < 9; i++)
        begin
            sum_next = sum_next + SW'(grid_reg[i]);
        end
    end

    assign prod = (2*SW+1)'(sum_reg) * (2*SW+1)'(MUL);
    assign quot = prod[SH +: PB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                window_reg[i] <= '0;
                grid_reg[i]   <= '0;
            end
        end
        else
        begin
            window_reg <= window_next;
            grid_reg   <= grid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        sum_reg  <= sum_next;
    end

endmodule

### hw/rtl/rgb_median_then_mean_filter_top.sv
// Top level of the RGB median-then-mean filter: group sequencing, three channel lanes,
// result merge and two-entry output queue. Depends on rgbmm_pkg and rgbmm_lane.
`timescale 1ns / 1ps

// Takes one pixel per cycle while in_stall is low. A group is 33 pixels when new_row is set
// on its first pixel, otherwise 15; each group yields one result item carrying
// floor((sum of nine medians + centre median)/10) per channel, which passes the window,
// row-sort, median-grid and sum registers into a two-entry output queue. in_stall rises
// only when that queue plus the results still in the pipeline would reach two entries, so
// input flows without pause unless the output side holds results back.
module rgb_median_then_mean_filter_top #(
    parameter int PIXEL_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic       new_row,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue
);

    localparam int PB = PIXEL_BITS;

    typedef struct packed {
        logic [PB-1:0] r;
        logic [PB-1:0] g;
        logic [PB-1:0] b;
    } rgb_t;

    logic [5:0]               pos_reg;
    logic [5:0]               pos_next;
    logic [3:0]               step_reg;
    logic [3:0]               step_next;
    logic [3:0]               off_reg;
    logic [3:0]               off_next;
    logic                     row_reg;
    logic                     row_next;
    rgbmm_pkg::grid_op_t      ctl1_reg;
    rgbmm_pkg::grid_op_t      ctl1_next;
    rgbmm_pkg::grid_op_t      ctl2_reg;
    logic                     emit3_reg;
    logic                     emit4_reg;
    rgbmm_pkg::win_op_t       win_op;
    rgbmm_pkg::step_kind_t    kind;
    logic [3:0]               med_idx;
    logic                     accept;
    logic                     first;
    logic                     row;
    logic                     last;
    logic                     step_end;
    logic [2:0]               pending;
    rgb_t                     quot;
    rgb_t                     fifo_mem [2];
    logic                     wr_ptr_reg;
    logic                     rd_ptr_reg;
    logic [1:0]               cnt_reg;
    logic                     push;
    logic                     pop;

    assign pending = 3'(cnt_reg) + 3'(ctl1_reg.emit) + 3'(ctl2_reg.emit)
                   + 3'(emit3_reg) + 3'(emit4_reg);
    assign in_stall = (pending >= 3'd2);
    assign accept = in_valid && !in_stall;

    assign first   = (pos_reg == 6'd0);
    assign row     = first ? new_row : row_reg;
    assign kind    = row ? rgbmm_pkg::row_kind(step_reg) : rgbmm_pkg::mid_kind(step_reg);
    assign med_idx = row ? rgbmm_pkg::row_cell(step_reg) : rgbmm_pkg::mid_cell(step_reg);
    assign last  = (pos_reg == (row ? rgbmm_pkg::ROW_LAST_POS : rgbmm_pkg::MID_LAST_POS));
    assign step_end = (kind == rgbmm_pkg::STEP_FULL) ? (off_reg == 4'd8) : (off_reg == 4'd2);

    always_comb
    begin
        win_op.we    = accept;
        win_op.shift = accept && (kind != rgbmm_pkg::STEP_FULL) && (off_reg == 4'd0);
        win_op.kind  = kind;
        case (kind)
            rgbmm_pkg::STEP_FULL:  win_op.slot = off_reg;
            rgbmm_pkg::STEP_LEFT:  win_op.slot = 4'(off_reg * 4'd3 + 4'd2);
            rgbmm_pkg::STEP_RIGHT: win_op.slot = 4'(off_reg * 4'd3);
            rgbmm_pkg::STEP_UP:    win_op.slot = 4'(off_reg + 4'd6);
            default:               win_op.slot = off_reg;
        endcase
    end

    always_comb
    begin
        ctl1_next.med   = accept && step_end;
        ctl1_next.idx   = med_idx;
        ctl1_next.shift = accept && first && !row;
        ctl1_next.emit  = accept && last;
        pos_next  = pos_reg;
        step_next = step_reg;
        off_next  = off_reg;
        row_next  = row_reg;
        if (accept)
        begin
            row_next = row;
            if (last)
            begin
                pos_next  = '0;
                step_next = '0;
                off_next  = '0;
            end
            else
            begin
                pos_next = pos_reg + 6'd1;
                if (step_end)
                begin
                    off_next  = '0;
                    step_next = step_reg + 4'd1;
                end
                else
                begin
                    off_next = off_reg + 4'd1;
                end
            end
        end
    end

    rgbmm_lane #(.PB(PB)) u_lane_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (PB'(red)),
        .win_op  (win_op),
        .grid_op (ctl2_reg),
        .quot    (quot.r)
    );

    rgbmm_lane #(.PB(PB)) u_lane_g (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (PB'(green)),
        .win_op  (win_op),
        .grid_op (ctl2_reg),
        .quot    (quot.g)
    );

    rgbmm_lane #(.PB(PB)) u_lane_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (PB'(blue)),
        .win_op  (win_op),
        .grid_op (ctl2_reg),
        .quot    (quot.b)
    );

    assign push      = emit4_reg;
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign out_red   = 8'(fifo_mem[rd_ptr_reg].r);
    assign out_green = 8'(fifo_mem[rd_ptr_reg].g);
    assign out_blue  = 8'(fifo_mem[rd_ptr_reg].b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            step_reg   <= '0;
            off_reg    <= '0;
            row_reg    <= 1'b0;
            ctl1_reg   <= '0;
            ctl2_reg   <= '0;
            emit3_reg  <= 1'b0;
            emit4_reg  <= 1'b0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            step_reg  <= step_next;
            off_reg   <= off_next;
            row_reg   <= row_next;
            ctl1_reg  <= ctl1_next;
            ctl2_reg  <= ctl1_reg;
            emit3_reg <= ctl2_reg.emit;
            emit4_reg <= emit3_reg;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= 2'(cnt_reg + 2'(push) - 2'(pop));
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= quot;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != 2'd2 || pop))
        else $error("output queue overflow");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg <= rgbmm_pkg::ROW_LAST_POS) && (row_reg || first || pos_reg <= rgbmm_pkg::MID_LAST_POS))
        else $error("group position out of range");

    a_emit_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (pos_reg == 6'd0 && step_reg == 4'd0 && off_reg == 4'd0))
        else $error("group did not restart after result");

endmodule

### verif/tb_top.sv
// Self-checking testbench for rgb_median_then_mean_filter_top: drives pixel groups with
// random gaps, predicts the filtered result per group, compares at the output. Needs rgbmm_pkg.
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT = 20000;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       nr;
        bit         hold;
    } pixel_t;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_stall;
    logic [7:0] red = 0, green = 0, blue = 0;
    logic       new_row = 0;
    logic       out_valid;
    logic       out_stall = 0;
    logic [7:0] out_red, out_green, out_blue;

    pixel_t pending_pixels[$];
    rgb_t   expected_rgb[$];
    int     errors = 0;
    int     results_seen = 0;
    int     pixels_sent = 0;
    int     idle_cycles = 0;
    int     send_gap = 0;
    int     stall_gap = 0;
    bit     waiting_drain = 0;

    logic [7:0] win[3][9];
    logic [7:0] med[3][9];
    int         grp_pos = 0;
    bit         grp_row = 0;

    rgb_median_then_mean_filter_top i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .red(red), .green(green), .blue(blue), .new_row(new_row),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] median_of_nine(input logic [7:0] w[9]);
        logic [7:0] v[9];
        logic [7:0] t;
        v = w;
        for (int i = 0; i < 9; i++)
            for (int j = 0; j < 8 - i; j++)
                if (v[j] > v[j + 1])
                begin
                    t = v[j];
                    v[j] = v[j + 1];
                    v[j + 1] = t;
                end
        return v[4];
    endfunction

    function automatic logic [7:0] weighted_mean(input logic [7:0] m[9]);
        int s;
        s = m[4];
        for (int i = 0; i < 9; i++)
            s += m[i];
        return 8'(s / 10);
    endfunction

    // Advance the filter state by one pixel; push a result when the group closes.
    task automatic filter_pixel(input pixel_t p);
        logic [7:0] px[3];
        int         pos, step, off, slot, last;
        rgbmm_pkg::step_kind_t kind;
        logic [3:0] med_idx;
        rgb_t       res;
        px[0] = p.r;
        px[1] = p.g;
        px[2] = p.b;
        if (grp_pos == 0)
        begin
            grp_row = p.nr;
            if (!grp_row)
                for (int c = 0; c < 3; c++)
                    for (int y = 0; y < 3; y++)
                    begin
                        med[c][y * 3] = med[c][y * 3 + 1];
                        med[c][y * 3 + 1] = med[c][y * 3 + 2];
                    end
        end
        pos = grp_pos;
        last = grp_row ? int'(rgbmm_pkg::ROW_LAST_POS) : int'(rgbmm_pkg::MID_LAST_POS);
        if (pos < 9)
        begin
            step = 0;
            off = pos;
        end
        else
        begin
            step = 1 + (pos - 9) / 3;
            off = (pos - 9) % 3;
        end
        kind = grp_row ? rgbmm_pkg::row_kind(4'(step)) : rgbmm_pkg::mid_kind(4'(step));
        med_idx = grp_row ? rgbmm_pkg::row_cell(4'(step)) : rgbmm_pkg::mid_cell(4'(step));
        for (int c = 0; c < 3; c++)
        begin
            if (kind != rgbmm_pkg::STEP_FULL && off == 0)
            begin
                for (int y = 0; y < 3; y++)
                    if (kind == rgbmm_pkg::STEP_LEFT)
                    begin
                        win[c][y * 3] = win[c][y * 3 + 1];
                        win[c][y * 3 + 1] = win[c][y * 3 + 2];
                    end
                    else if (kind == rgbmm_pkg::STEP_RIGHT)
                    begin
                        win[c][y * 3 + 2] = win[c][y * 3 + 1];
                        win[c][y * 3 + 1] = win[c][y * 3];
                    end
                if (kind == rgbmm_pkg::STEP_UP)
                    for (int x = 0; x < 3; x++)
                    begin
                        win[c][x] = win[c][3 + x];
                        win[c][3 + x] = win[c][6 + x];
                    end
            end
            case (kind)
                rgbmm_pkg::STEP_FULL:  slot = off;
                rgbmm_pkg::STEP_LEFT:  slot = off * 3 + 2;
                rgbmm_pkg::STEP_RIGHT: slot = off * 3;
                default:               slot = 6 + off;
            endcase
            win[c][slot % 9] = px[c];
            if ((kind == rgbmm_pkg::STEP_FULL && off == 8)
                || (kind != rgbmm_pkg::STEP_FULL && off == 2))
                med[c][med_idx] = median_of_nine(win[c]);
        end
        if (pos == last)
        begin
            grp_pos = 0;
            res.r = weighted_mean(med[0]);
            res.g = weighted_mean(med[1]);
            res.b = weighted_mean(med[2]);
            expected_rgb.push_back(res);
        end
        else
            grp_pos = pos + 1;
    endtask

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mode 0 random, 1 all zero, 2 all max, 3 wild flag mid-group
    task automatic queue_group(input bit row, input int mode, input bit hold_first);
        pixel_t p;
        int n;
        n = row ? 33 : 15;
        for (int i = 0; i < n; i++)
        begin
            p.r = mode == 1 ? 8'h00 : mode == 2 ? 8'hFF : 8'($urandom);
            p.g = mode == 1 ? 8'h00 : mode == 2 ? 8'hFF : 8'($urandom);
            p.b = mode == 1 ? 8'h00 : mode == 2 ? 8'hFF : 8'($urandom);
            p.nr = i == 0 ? row : (mode == 3 ? 1'($urandom) : ~row);
            p.hold = hold_first && i == 0;
            pending_pixels.push_back(p);
        end
    endtask

    initial
    begin
        queue_group(0, 0, 0);
        queue_group(1, 1, 0);
        queue_group(1, 2, 0);
        queue_group(0, 2, 0);
        queue_group(0, 1, 0);
        queue_group(1, 3, 0);
        queue_group(0, 3, 1);
        while (pending_pixels.size() < 1450)
            queue_group($urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0 ? 3 : 0,
                        $urandom_range(0, 30) == 0);
        repeat (8) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                filter_pixel('{red, green, blue, new_row, 0});
                pixels_sent++;
                void'(pending_pixels.pop_front());
                send_gap = gap_len();
                if (pixels_sent > 300 && pixels_sent < 500) send_gap = 0;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_pixels.size() > 0 && pending_pixels[0].hold
                    && expected_rgb.size() > 0)
                    in_valid <= 0;
                else if (pending_pixels.size() > 0 && send_gap == 0)
                begin
                    in_valid <= 1;
                    red <= pending_pixels[0].r;
                    green <= pending_pixels[0].g;
                    blue <= pending_pixels[0].b;
                    new_row <= pending_pixels[0].nr;
                    if (pending_pixels[0].hold)
                        pending_pixels[0].hold = 0;
                end
                else
                begin
                    in_valid <= 0;
                    if (send_gap > 0) send_gap--;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_rgb.size() == 0)
                begin
                    $display("%0t: unexpected item %h %h %h", $time, out_red, out_green,
                             out_blue);
                    errors++;
                end
                else
                begin
                    rgb_t e;
                    e = expected_rgb.pop_front();
                    if (e.r !== out_red)
                    begin
                        $display("%0t: out_red exp %h got %h", $time, e.r, out_red);
                        errors++;
                    end
                    if (e.g !== out_green)
                    begin
                        $display("%0t: out_green exp %h got %h", $time, e.g, out_green);
                        errors++;
                    end
                    if (e.b !== out_blue)
                    begin
                        $display("%0t: out_blue exp %h got %h", $time, e.b, out_blue);
                        errors++;
                    end
                end
            end
            if (stall_gap > 0)
            begin
                out_stall <= 1;
                stall_gap--;
            end
            else if (pixels_sent > 300 && pixels_sent < 500)
                out_stall <= 0;
            else
            begin
                out_stall <= 0;
                stall_gap = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= LIMIT)
            begin
                $display("timeout: %0d results pending", expected_rgb.size());
                $display("[rgb_median_then_mean_filter_top] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        wait (rst_n);
        wait (pending_pixels.size() == 0 && expected_rgb.size() == 0 && !in_valid);
        repeat (20) @(posedge clk);
        $display("Ran %0d pixels as row-start and ordinary groups, checked %0d filtered items.",
                 pixels_sent, results_seen);
        if (errors == 0 && expected_rgb.size() == 0)
            $display("[rgb_median_then_mean_filter_top] OK");
        else
            $display("[rgb_median_then_mean_filter_top] ERROR");
        $finish;
    end
endmodule

### sim.f
hw/rtl/rgbmm_pkg.sv
hw/rtl/rgbmm_lane.sv
hw/rtl/rgb_median_then_mean_filter_top.sv
verif/tb_top.sv
